/* rtl/b32d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package b32d_pkg;

  // Status codes reported with every result
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_SYMBOL   = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  // Register map: byte address 4*i, word index taken from paddr[2]
  localparam int unsigned PADDR_W         = 3;
  localparam logic        REG_OUT_LIMIT   = 1'b0;
  localparam logic [7:0]  OUT_LIMIT_RESET = 8'd64;

  // Symbol classes: 0..31 carry a value, the two upper codes do not
  localparam logic [5:0] SYM_SKIP = 6'd32;
  localparam logic [5:0] SYM_BAD  = 6'd33;

  localparam logic [7:0] ALPHA_COUNT = 8'd26;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_symbol;
  } b32d_req_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [1:0] status;
    logic [7:0] byte_count;
  } b32d_rsp_t;

  // Map one ASCII character to its 5-bit value or to a skip / bad class
  function automatic logic [5:0] b32d_classify(input logic [7:0] c);
    logic [5:0] code;
    code = SYM_BAD;
    case (c) inside
      [8'h41:8'h5A]: code = {1'b0, 5'(c - 8'h41)};
      [8'h61:8'h7A]: code = {1'b0, 5'(c - 8'h61)};
      [8'h32:8'h37]: code = {1'b0, 5'(c - 8'h32 + ALPHA_COUNT)};
      8'h20, 8'h09, 8'h0D, 8'h0A, 8'h3D: code = SYM_SKIP;
      default: code = SYM_BAD;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/base32_stream_decoder.sv */
// Base32 stream decoder: one ASCII character per request, one result each.
// Input channel: in_valid_i / in_stall_o with in_req_i (symbol, last_symbol).
// Output channel: out_valid_o / out_stall_i with out_rsp_o (byte_valid,
// data_byte, status, byte_count). A request moves across either channel at
// a clock edge where valid is high and stall is low.
// The request passes through the input register, then the result register;
// a stall on the output channel can hold it in the input register between
// the two. Throughput: one character per cycle while the receiver does not
// stall, set by the single decode step between the two registers.
// When the receiver stalls, the result register holds; the input register
// still takes one more request if it is empty, then in_stall_o rises until
// the result drains. The request marked last_symbol clears the string state
// after its result is formed.
// Reset clears both registers' valid flags and the string state, and sets
// out_limit to 64. out_limit sits at byte address 0 of the APB port. The user
// must write it only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module base32_stream_decoder (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire b32d_pkg::b32d_req_t             in_req_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output b32d_pkg::b32d_rsp_t                  out_rsp_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [b32d_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import b32d_pkg::*;

  logic       in_valid_q;
  b32d_req_t  in_req_q;
  logic       out_valid_q;
  b32d_rsp_t  out_rsp_q;
  b32d_rsp_t  rsp;
  logic       advance;
  logic [7:0] out_limit_q;

  // Move the held request on when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_req_q <= in_req_i;
    end
  end

  b32d_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .req_i       (in_req_q),
    .out_limit_i (out_limit_q),
    .rsp_o       (rsp)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q <= OUT_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_OUT_LIMIT)) begin
      out_limit_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUT_LIMIT) ? {24'd0, out_limit_q} : 32'd0;

endmodule

`default_nettype wire

/* rtl/b32d_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module b32d_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire b32d_pkg::b32d_req_t req_i,
  input  wire logic [7:0]         out_limit_i,
  output b32d_pkg::b32d_rsp_t     rsp_o
);
  import b32d_pkg::*;

  logic [11:0] bit_buffer_q, bit_buffer_d, work_buffer;
  logic [3:0]  bit_count_q, bit_count_d, work_count, count_sum;
  logic [7:0]  decoded_count_q, decoded_count_d, work_decoded;
  logic [1:0]  error_code_q, error_code_d, work_error;
  logic [5:0]  code;
  logic [2:0]  shift;

  // Decode the held character against the current string state
  always_comb begin
    code         = b32d_classify(req_i.symbol);
    work_buffer  = bit_buffer_q;
    work_count   = bit_count_q;
    work_decoded = decoded_count_q;
    work_error   = error_code_q;
    count_sum    = bit_count_q + 4'd5;
    shift        = count_sum[2:0];
    rsp_o        = '0;

    if (error_code_q == ERR_NONE) begin
      if (code == SYM_BAD) begin
        work_error = ERR_SYMBOL;
      end else if (!code[5]) begin
        work_buffer = {bit_buffer_q[6:0], code[4:0]};
        work_count  = count_sum;
        if (count_sum >= 4'd8) begin
          if (decoded_count_q >= out_limit_i) begin
            work_error = ERR_OVERFLOW;
          end else begin
            // count_sum lies in 8..12, so its low bits give the shift
            work_count       = {1'b0, shift};
            rsp_o.byte_valid = 1'b1;
            rsp_o.data_byte  = 8'(work_buffer >> shift);
            work_decoded     = decoded_count_q + 8'd1;
          end
        end
      end
    end

    rsp_o.status     = work_error;
    rsp_o.byte_count = work_decoded;

    // Drop all string state after the final character
    if (req_i.last_symbol) begin
      bit_buffer_d    = '0;
      bit_count_d     = '0;
      decoded_count_d = '0;
      error_code_d    = ERR_NONE;
    end else begin
      bit_buffer_d    = work_buffer;
      bit_count_d     = work_count;
      decoded_count_d = work_decoded;
      error_code_d    = work_error;
    end
  end

  // Commit state when the request moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_buffer_q    <= '0;
      bit_count_q     <= '0;
      decoded_count_q <= '0;
      error_code_q    <= ERR_NONE;
    end else if (advance_i) begin
      bit_buffer_q    <= bit_buffer_d;
      bit_count_q     <= bit_count_d;
      decoded_count_q <= decoded_count_d;
      error_code_q    <= error_code_d;
    end
  end

endmodule

`default_nettype wire
